// File: rtl/soba_pkg.sv
// Shared types, field widths, request codes and state encoding for the
// slot occupancy bitmap allocator. No dependencies.
`timescale 1ns / 1ps

package soba_pkg;

  localparam int SLOT_W = 11;   // slot numbers, capacity and counts
  localparam int KIND_W = 3;
  localparam int WANT_W = 7;
  localparam int WORD_W = 64;   // bitmap word, one bit per slot
  localparam int BIT_W  = 6;    // bit position inside a word
  localparam int WIDX_W = 6;    // word index, wide enough for last word plus one

  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEVERAL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COMPACT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_SCAN,
    ST_MULTI
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_id;
    logic [WANT_W-1:0] wanted;
    logic              set_occupied;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_found;
    logic              is_occupied;
    logic              compact;
    logic [SLOT_W-1:0] used_count;
    logic [SLOT_W-1:0] free_count;
    logic              last;
  } out_item_t;

  // Position of the lowest set bit; the word is isolated to one hot first,
  // so the encode is a plain OR over independent bits.
  function automatic logic [BIT_W-1:0] lsb_index(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] oh;
    logic [BIT_W-1:0]  idx;
    oh  = v & (~v + {{(WORD_W-1){1'b0}}, 1'b1});
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (oh[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Bits of word w that lie inside [start, last] of the current search.
  function automatic logic [WORD_W-1:0] word_mask(input logic [WIDX_W-1:0] w,
                                                  input logic [WIDX_W-1:0] sw,
                                                  input logic [BIT_W-1:0]  sb,
                                                  input logic [WIDX_W-1:0] lw,
                                                  input logic [BIT_W-1:0]  lb);
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    lo = (w == sw) ? ({WORD_W{1'b1}} << sb) : {WORD_W{1'b1}};
    hi = (w == lw) ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lb)) : {WORD_W{1'b1}};
    return lo & hi;
  endfunction

endpackage

// File: rtl/soba_map_ram.sv
// Occupancy bitmap storage: one 64-bit word per entry, one read and one write
// port, registered read data, and a clearing sweep after reset. Uses soba_pkg.
`timescale 1ns / 1ps

module soba_map_ram #(
  parameter int WORDS = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [soba_pkg::WORD_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [soba_pkg::WORD_W-1:0] wr_data,
  output logic                        ready
);

  logic [soba_pkg::WORD_W-1:0] mem [WORDS];
  logic [soba_pkg::WORD_W-1:0] rd_data_r;
  logic                        clr_busy_r;
  logic                        clr_busy_nxt;
  logic [AW-1:0]               clr_idx_r;
  logic [AW-1:0]               clr_idx_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + {{(AW-1){1'b0}}, 1'b1};
      if (clr_idx_r == AW'(WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // The sweep owns the write port until every word is zero.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = ~clr_busy_r;

endmodule

// File: rtl/slot_occupancy_bitmap_allocator.sv
// Top level of the slot occupancy bitmap allocator: request sequencer, counts,
// configuration register and result register. Uses soba_pkg and soba_map_ram.
//
//   channel  direction  signals                      payload
//   in       input      in_valid / in_ready          soba_pkg::in_item_t
//   out      output     out_valid / out_ready        soba_pkg::out_item_t
//   cfg      input      cfg_valid / cfg_ready        slot_capacity, 11 bits
//
// Query and set read the map word, then give the result and write back.
// First-free and compact checks read one bitmap word at a time until they can
// answer; several-free scans the words and reports one slot per transfer.
// Reset clears the map with a sweep over every bitmap word, during which
// in_ready is low; cfg writes are taken throughout.
// A stalled result register holds the sequencer but not the next transfer in.
`timescale 1ns / 1ps

module slot_occupancy_bitmap_allocator #(
  parameter int MAX_SLOTS  = 1024,
  parameter int MAX_REPORT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  soba_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output soba_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [soba_pkg::SLOT_W-1:0]   cfg_data
);

  localparam int WORDS = (MAX_SLOTS + soba_pkg::WORD_W - 1) / soba_pkg::WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = (AW > soba_pkg::WIDX_W) ? AW : soba_pkg::WIDX_W;
  localparam int MAXC  = (MAX_SLOTS > (1 << soba_pkg::SLOT_W) - 1) ?
                         (1 << soba_pkg::SLOT_W) - 1 : MAX_SLOTS;
  localparam logic [soba_pkg::SLOT_W-1:0] CAP_MAX   = soba_pkg::SLOT_W'(MAXC);
  localparam logic [soba_pkg::WANT_W-1:0] REPORT_MX = soba_pkg::WANT_W'(MAX_REPORT);

  soba_pkg::state_t              state_r, state_nxt;
  logic [soba_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic                          bad_r, bad_nxt;
  logic                          setv_r, setv_nxt;
  logic [soba_pkg::WIDX_W-1:0]   start_w_r, start_w_nxt;
  logic [soba_pkg::BIT_W-1:0]    start_b_r, start_b_nxt;
  logic [soba_pkg::WANT_W-1:0]   lim_r, lim_nxt;
  logic [soba_pkg::WANT_W-1:0]   cnt_r, cnt_nxt;
  logic [soba_pkg::WIDX_W-1:0]   rw_r, rw_nxt;      // word held in read data
  logic [soba_pkg::WIDX_W-1:0]   mw_r, mw_nxt;      // word held in mask_r
  logic [soba_pkg::WORD_W-1:0]   mask_r, mask_nxt;
  logic                          pend_v_r, pend_v_nxt;
  logic [soba_pkg::SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic                          seen_r, seen_nxt;
  logic [soba_pkg::SLOT_W-1:0]   used_r, used_nxt;
  logic [soba_pkg::SLOT_W-1:0]   cap_r;
  logic                          out_valid_r, out_valid_nxt;
  soba_pkg::out_item_t           out_data_r;

  logic                          ram_ready;
  logic                          rd_en;
  logic [soba_pkg::WIDX_W-1:0]   rd_idx;
  logic [IW-1:0]                 rd_idx_ext;
  logic [IW-1:0]                 wr_idx_ext;
  logic [soba_pkg::WORD_W-1:0]   rd_data;
  logic                          wr_en;
  logic [soba_pkg::WORD_W-1:0]   wr_data;

  logic [soba_pkg::SLOT_W-1:0]   cap_eff;
  logic [soba_pkg::SLOT_W-1:0]   cap_m1;
  logic [soba_pkg::WIDX_W-1:0]   last_w;
  logic [soba_pkg::BIT_W-1:0]    last_b;
  logic [soba_pkg::WORD_W-1:0]   cur_mask;
  logic [soba_pkg::WORD_W-1:0]   free_w;
  logic [soba_pkg::WORD_W-1:0]   occ_w;
  logic [soba_pkg::WORD_W-1:0]   free_lsb;
  logic [soba_pkg::WORD_W-1:0]   above_lsb;
  logic [soba_pkg::WORD_W-1:0]   bit_oh;
  logic                          cur_bit;
  logic [soba_pkg::WIDX_W+soba_pkg::BIT_W-1:0] scan_pos;
  logic [soba_pkg::WIDX_W+soba_pkg::BIT_W-1:0] multi_pos;
  logic [soba_pkg::SLOT_W-1:0]   scan_slot;
  logic [soba_pkg::SLOT_W-1:0]   multi_slot;
  logic [soba_pkg::SLOT_W-1:0]   sid_m1;
  logic                          sid_ok;
  logic                          out_free;
  logic                          load;
  soba_pkg::out_item_t           res;
  logic [soba_pkg::SLOT_W-1:0]   used_res;

  assign cap_eff   = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign cap_m1    = cap_eff - {{(soba_pkg::SLOT_W-1){1'b0}}, 1'b1};
  assign last_w    = soba_pkg::WIDX_W'(cap_m1[soba_pkg::SLOT_W-1:soba_pkg::BIT_W]);
  assign last_b    = cap_m1[soba_pkg::BIT_W-1:0];
  assign cur_mask  = soba_pkg::word_mask(rw_r, start_w_r, start_b_r, last_w, last_b);
  assign free_w    = ~rd_data & cur_mask;
  assign occ_w     = rd_data & cur_mask;
  assign free_lsb  = free_w & (~free_w + {{(soba_pkg::WORD_W-1){1'b0}}, 1'b1});
  // Everything strictly above the first free bit of this word.
  assign above_lsb = ~(free_lsb | (free_lsb - {{(soba_pkg::WORD_W-1){1'b0}}, 1'b1}));
  assign bit_oh    = {{(soba_pkg::WORD_W-1){1'b0}}, 1'b1} << start_b_r;
  assign cur_bit   = |(rd_data & bit_oh);
  assign scan_pos  = {rw_r, soba_pkg::lsb_index(free_w)} + 1'b1;
  assign multi_pos = {mw_r, soba_pkg::lsb_index(mask_r)} + 1'b1;
  assign scan_slot  = scan_pos[soba_pkg::SLOT_W-1:0];
  assign multi_slot = multi_pos[soba_pkg::SLOT_W-1:0];
  assign sid_m1    = in_data.slot_id - {{(soba_pkg::SLOT_W-1){1'b0}}, 1'b1};
  assign sid_ok    = (in_data.slot_id != '0) && (in_data.slot_id <= cap_eff);
  assign out_free  = ~out_valid_r | out_ready;
  assign in_ready  = (state_r == soba_pkg::ST_IDLE) && ram_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    bad_nxt       = bad_r;
    setv_nxt      = setv_r;
    start_w_nxt   = start_w_r;
    start_b_nxt   = start_b_r;
    lim_nxt       = lim_r;
    cnt_nxt       = cnt_r;
    rw_nxt        = rw_r;
    mw_nxt        = mw_r;
    mask_nxt      = mask_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    seen_nxt      = seen_r;
    used_nxt      = used_r;
    rd_en         = 1'b0;
    rd_idx        = rw_r + 1'b1;
    wr_en         = 1'b0;
    wr_data       = setv_r ? (rd_data | bit_oh) : (rd_data & ~bit_oh);
    load          = 1'b0;
    res           = '0;
    res.last      = 1'b1;
    used_res      = used_r;

    unique case (state_r)
      soba_pkg::ST_IDLE: begin
        if (in_valid && ram_ready) begin
          kind_nxt    = in_data.kind;
          setv_nxt    = in_data.set_occupied;
          lim_nxt     = (in_data.wanted > REPORT_MX) ? REPORT_MX : in_data.wanted;
          cnt_nxt     = '0;
          mask_nxt    = '0;
          pend_v_nxt  = 1'b0;
          seen_nxt    = 1'b0;
          bad_nxt     = 1'b0;
          start_w_nxt = soba_pkg::WIDX_W'(sid_m1[soba_pkg::SLOT_W-1:soba_pkg::BIT_W]);
          start_b_nxt = sid_m1[soba_pkg::BIT_W-1:0];
          if (in_data.kind == soba_pkg::KIND_COMPACT) begin
            start_w_nxt = '0;
            start_b_nxt = '0;
          end
          rw_nxt = start_w_nxt;
          rd_en  = 1'b1;
          rd_idx = start_w_nxt;
          if (in_data.kind == soba_pkg::KIND_COMPACT) begin
            // With a slot capacity of zero the check answers at once.
            state_nxt = (cap_eff == '0) ? soba_pkg::ST_SINGLE : soba_pkg::ST_SCAN;
          end else if (in_data.kind > soba_pkg::KIND_COMPACT || !sid_ok) begin
            bad_nxt   = 1'b1;
            state_nxt = soba_pkg::ST_SINGLE;
          end else if (in_data.kind == soba_pkg::KIND_FIRST) begin
            state_nxt = soba_pkg::ST_SCAN;
          end else if (in_data.kind == soba_pkg::KIND_SEVERAL) begin
            state_nxt = soba_pkg::ST_MULTI;
          end else begin
            state_nxt = soba_pkg::ST_SINGLE;
          end
        end
      end

      soba_pkg::ST_SINGLE: begin
        res.ok = ~bad_r;
        if (!bad_r && kind_r == soba_pkg::KIND_COMPACT) begin
          res.compact = 1'b1;
        end
        if (!bad_r && kind_r == soba_pkg::KIND_QUERY) begin
          res.is_occupied = cur_bit;
        end
        if (!bad_r && kind_r == soba_pkg::KIND_SET) begin
          if (cur_bit && !setv_r && used_r != '0) begin
            used_res = used_r - 1'b1;
          end else if (!cur_bit && setv_r && used_r < CAP_MAX) begin
            used_res = used_r + 1'b1;
          end
        end
        if (out_free) begin
          load      = 1'b1;
          state_nxt = soba_pkg::ST_IDLE;
          if (!bad_r && kind_r == soba_pkg::KIND_SET) begin
            wr_en    = 1'b1;
            used_nxt = used_res;
          end
        end
      end

      soba_pkg::ST_SCAN: begin
        res.ok = 1'b1;
        if (kind_r == soba_pkg::KIND_FIRST) begin
          if (free_w != '0 || rw_r == last_w) begin
            res.slot_found = (free_w != '0) ? scan_slot : '0;
            if (out_free) begin
              load      = 1'b1;
              state_nxt = soba_pkg::ST_IDLE;
            end
          end else begin
            rd_en  = 1'b1;
            rw_nxt = rw_r + 1'b1;
          end
        end else begin
          // Compact fails on any occupied bit past the first free one.
          if (seen_r ? (occ_w != '0) : ((free_w != '0) && ((occ_w & above_lsb) != '0))) begin
            res.compact = 1'b0;
            if (out_free) begin
              load      = 1'b1;
              state_nxt = soba_pkg::ST_IDLE;
            end
          end else if (rw_r == last_w) begin
            res.compact = 1'b1;
            if (out_free) begin
              load      = 1'b1;
              state_nxt = soba_pkg::ST_IDLE;
            end
          end else begin
            seen_nxt = seen_r | (free_w != '0);
            rd_en    = 1'b1;
            rw_nxt   = rw_r + 1'b1;
          end
        end
      end

      soba_pkg::ST_MULTI: begin
        // One found slot is held back so the final transfer can carry last.
        res.ok = 1'b1;
        if (cnt_r == lim_r || (mask_r == '0 && rw_r > last_w)) begin
          res.slot_found = pend_v_r ? pend_slot_r : '0;
          if (out_free) begin
            load      = 1'b1;
            state_nxt = soba_pkg::ST_IDLE;
          end
        end else if (mask_r != '0) begin
          if (pend_v_r) begin
            res.slot_found = pend_slot_r;
            res.last       = 1'b0;
          end
          if (!pend_v_r || out_free) begin
            load          = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = multi_slot;
            mask_nxt      = mask_r & (mask_r - {{(soba_pkg::WORD_W-1){1'b0}}, 1'b1});
            cnt_nxt       = cnt_r + 1'b1;
          end
        end else begin
          mask_nxt = free_w;
          mw_nxt   = rw_r;
          rd_en    = 1'b1;
          rw_nxt   = rw_r + 1'b1;
        end
      end

      default: begin
        state_nxt = soba_pkg::ST_IDLE;
      end
    endcase

    res.used_count = used_res;
    res.free_count = (cap_eff > used_res) ? (cap_eff - used_res) : '0;
  end

  assign out_valid_nxt = load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= soba_pkg::ST_IDLE;
      used_r      <= '0;
      cap_r       <= soba_pkg::SLOT_W'(1024);
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    bad_r       <= bad_nxt;
    setv_r      <= setv_nxt;
    start_w_r   <= start_w_nxt;
    start_b_r   <= start_b_nxt;
    lim_r       <= lim_nxt;
    rw_r        <= rw_nxt;
    mw_r        <= mw_nxt;
    mask_r      <= mask_nxt;
    pend_slot_r <= pend_slot_nxt;
    seen_r      <= seen_nxt;
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Read and write of one word never overlap: the write back happens in the
  // cycle that ends a request, and the next read is issued after it.
  assign rd_idx_ext = IW'(rd_idx);
  assign wr_idx_ext = IW'(rw_r);

  soba_map_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_ext[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_ext[AW-1:0]),
    .wr_data (wr_data),
    .ready   (ram_ready)
  );

  a_write_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == soba_pkg::ST_SINGLE) && (kind_r == soba_pkg::KIND_SET) && !bad_r)
    else $error("bitmap written outside a set request");

  a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == soba_pkg::ST_MULTI) |-> (cnt_r <= lim_r))
    else $error("reported more free slots than requested");

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CAP_MAX)
    else $error("occupied count beyond the slot range");

  a_not_last_only_multi: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !res.last) |-> (state_r == soba_pkg::ST_MULTI) && pend_v_r)
    else $error("non-final result outside a multi-slot report");

  a_result_reg_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule
